// ===== rtl/dsss_bpsk_modulator_top_macros.svh =====
`ifndef DSSS_BPSK_MODULATOR_TOP_MACROS_SVH
`define DSSS_BPSK_MODULATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every clk edge outside reset
`define DSSSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clk edge outside reset
`define DSSSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dsssb_pkg.sv =====
`default_nettype none
package dsssb_pkg;

	localparam int CODE_MAX = 128;
	localparam int POS_W    = $clog2(CODE_MAX);

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PHASE_STEP     = 3'd0,
		REG_BIT_CHIPS      = 3'd1,
		REG_CHIP_SAMPLES   = 3'd2,
		REG_CODE_LEN       = 3'd3,
		REG_CODE_BITS_LOW  = 3'd4,
		REG_CODE_BITS_HIGH = 3'd5
	} cfg_reg_t;

	// Effective configuration, zero values already clamped
	typedef struct packed {
		logic [31:0]         phase_step;
		logic [15:0]         bit_chips;
		logic [15:0]         chip_samples;
		logic [7:0]          code_len;
		logic [CODE_MAX-1:0] code_bits;
	} cfg_t;

	// Stage 1 payload: carrier phase fields and chip decision
	typedef struct packed {
		logic [1:0] quad;
		logic [7:0] idx;
		logic       chip_sign;
		logic       bit_taken;
	} stage_t;

	// Quarter-wave cosine table, 256 entries of 15 bits
	typedef logic [255:0][14:0] rom_t;

	localparam longint C2      = 64'sd1324675880;
	localparam longint C4      = 64'sd272375561;
	localparam longint C6      = 64'sd22401990;
	localparam longint C8      = 64'sd987048;
	localparam longint C10     = 64'sd27060;
	localparam longint ONE_Q30 = 64'sd1073741824;

	// Q30 product, truncated toward zero
	function automatic longint q30_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		if (p < 0)
			return -((-p) >>> 30);
		return p >>> 30;
	endfunction

	// Table built at elaboration from the even polynomial in Q30
	function automatic rom_t build_cos_rom();
		rom_t   rom;
		longint odd;
		longint v;
		longint t;
		longint r;
		for (int k = 0; k < 256; k++) begin
			odd = longint'(2 * k + 1);
			v   = odd * odd * 64'sd4096;
			t   = C8 - q30_mul(v, C10);
			t   = C6 - q30_mul(v, t);
			t   = C4 - q30_mul(v, t);
			t   = C2 - q30_mul(v, t);
			r   = ONE_Q30 - q30_mul(v, t);
			if (r < 0)
				r = 0;
			if (r > ONE_Q30)
				r = ONE_Q30;
			r = (r * 64'sd32767 + 64'sd536870912) >>> 30;
			if (r > 32767)
				r = 32767;
			rom[k] = r[14:0];
		end
		return rom;
	endfunction

	localparam rom_t COS_ROM = build_cos_rom();

endpackage
`default_nettype wire

// ===== rtl/dsss_bpsk_modulator_top.sv =====
// Channel   Direction  Signals                                   Content
// s_*       in         s_tvalid s_tready s_tdata[7:0]             data bit per sample tick
// m_*       out        m_tvalid m_tready m_tdata[23:0] m_tuser    carrier sample
// cfg_*     in         cfg_valid cfg_ready cfg_index cfg_data     register writes
//
// One transaction in, one sample out; a new data transaction is taken every clock
// unless m_tready stalls the output. The path runs through the stage 1 register,
// then the cosine table and the output register.
// arst_n clears the counters, phase and pipeline valids; registers take their defaults.
// A stall on m_tready holds the output register and backs up through stage 1 to s_tready.
// cfg_ready is always high.
`default_nettype none
module dsss_bpsk_modulator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] data bit, [7:1] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [15:0] sample, [16] chip_sign, [23:17] zero
	output logic             m_tuser,   // [0] bit_taken
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import dsssb_pkg::*;

	cfg_t               cfg;
	logic               s1_valid;
	logic               s1_ready;
	stage_t             s1_data;
	logic signed [15:0] sample;
	logic               chip_sign;

	dsssb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dsssb_spread u_spread (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_bit   (s_tdata[0]),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.s1_data  (s1_data)
	);

	dsssb_carrier u_carrier (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.s1_data   (s1_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sample    (sample),
		.bit_taken (m_tuser),
		.chip_sign (chip_sign)
	);

	assign m_tdata = {7'd0, chip_sign, sample};

endmodule
`default_nettype wire

// ===== rtl/dsssb_cfg.sv =====
`default_nettype none
module dsssb_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [63:0]       cfg_data,
	output dsssb_pkg::cfg_t        cfg
);
	import dsssb_pkg::*;

	logic [31:0] phase_step_q;
	logic [15:0] bit_chips_q;
	logic [15:0] chip_samples_q;
	logic [7:0]  code_len_q;
	logic [63:0] code_low_q;
	logic [63:0] code_high_q;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= '0;
			bit_chips_q    <= 16'd1;
			chip_samples_q <= 16'd1;
			code_len_q     <= 8'd127;
			code_low_q     <= '0;
			code_high_q    <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PHASE_STEP:     phase_step_q   <= cfg_data[31:0];
				REG_BIT_CHIPS:      bit_chips_q    <= cfg_data[15:0];
				REG_CHIP_SAMPLES:   chip_samples_q <= cfg_data[15:0];
				REG_CODE_LEN:       code_len_q     <= cfg_data[7:0];
				REG_CODE_BITS_LOW:  code_low_q     <= cfg_data;
				REG_CODE_BITS_HIGH: code_high_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp zero counts to one and the code length to the code store size
	always_comb begin
		cfg.phase_step   = phase_step_q;
		cfg.bit_chips    = (bit_chips_q == '0) ? 16'd1 : bit_chips_q;
		cfg.chip_samples = (chip_samples_q == '0) ? 16'd1 : chip_samples_q;
		if (code_len_q == '0)
			cfg.code_len = 8'd1;
		else if (code_len_q > 8'(CODE_MAX))
			cfg.code_len = 8'(CODE_MAX);
		else
			cfg.code_len = code_len_q;
		cfg.code_bits = {code_high_q, code_low_q};
	end

endmodule
`default_nettype wire

// ===== rtl/dsssb_spread.sv =====
`default_nettype none
`include "dsss_bpsk_modulator_top_macros.svh"
module dsssb_spread (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dsssb_pkg::cfg_t cfg,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            in_bit,
	output logic                 s1_valid,
	input  wire logic            s1_ready,
	output dsssb_pkg::stage_t    s1_data
);
	import dsssb_pkg::*;

	logic [31:0]      phase_q;
	logic [15:0]      smp_cnt_q;
	logic [15:0]      chip_cnt_q;
	logic [POS_W-1:0] pos_q;
	logic             held_q;

	logic             s1_valid_q;
	stage_t           stage_s1;

	logic             accept;
	logic             bit_start;
	logic             eff_held;
	logic [POS_W-1:0] eff_pos;
	logic             code_bit;
	logic [16:0]      smp_inc;
	logic [16:0]      chip_inc;
	logic [POS_W:0]   pos_inc;
	logic             smp_wrap;
	logic             chip_wrap;
	logic             pos_wrap;

	assign in_ready = !s1_valid_q || s1_ready;
	assign accept   = in_valid && in_ready;

	// Bit start and chip decision for the current tick
	always_comb begin
		bit_start = (smp_cnt_q == '0) && (chip_cnt_q == '0);
		eff_held  = bit_start ? in_bit : held_q;
		eff_pos   = bit_start ? '0 : pos_q;
		code_bit  = cfg.code_bits[eff_pos];
		smp_inc   = {1'b0, smp_cnt_q} + 17'd1;
		chip_inc  = {1'b0, chip_cnt_q} + 17'd1;
		pos_inc   = {1'b0, eff_pos} + (POS_W+1)'(1);
		smp_wrap  = smp_inc >= {1'b0, cfg.chip_samples};
		chip_wrap = chip_inc >= {1'b0, cfg.bit_chips};
		pos_wrap  = pos_inc >= cfg.code_len;
	end

	// Modulator state, advanced once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			smp_cnt_q  <= '0;
			chip_cnt_q <= '0;
			pos_q      <= '0;
			held_q     <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_q + cfg.phase_step;
			held_q  <= eff_held;
			if (smp_wrap) begin
				smp_cnt_q  <= '0;
				pos_q      <= pos_wrap ? '0 : pos_inc[POS_W-1:0];
				chip_cnt_q <= chip_wrap ? '0 : chip_inc[15:0];
			end else begin
				smp_cnt_q <= smp_inc[15:0];
				pos_q     <= eff_pos;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (accept)
			s1_valid_q <= 1'b1;
		else if (s1_ready)
			s1_valid_q <= 1'b0;
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1.quad      <= phase_q[31:30];
			stage_s1.idx       <= phase_q[29:22];
			stage_s1.chip_sign <= eff_held ~^ code_bit;
			stage_s1.bit_taken <= bit_start;
		end
	end

	assign s1_valid = s1_valid_q;
	assign s1_data  = stage_s1;

	`DSSSB_ASSERT_NEXT(a_phase_step, accept,
		phase_q == $past(phase_q) + $past(cfg.phase_step), "phase did not advance")
	`DSSSB_ASSERT_NEXT(a_idle_hold, !accept,
		$stable(phase_q) && $stable(smp_cnt_q) && $stable(chip_cnt_q),
		"state moved without a transaction")
	`DSSSB_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s1_ready,
		s1_valid_q && $stable(stage_s1), "stage 1 lost while stalled")

endmodule
`default_nettype wire

// ===== rtl/dsssb_carrier.sv =====
`default_nettype none
`include "dsss_bpsk_modulator_top_macros.svh"
module dsssb_carrier (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s1_valid,
	output logic                   s1_ready,
	input  wire dsssb_pkg::stage_t s1_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic signed [15:0]     sample,
	output logic                   bit_taken,
	output logic                   chip_sign
);
	import dsssb_pkg::*;

	logic               valid_q;
	logic signed [15:0] sample_q;
	logic               taken_q;
	logic               sign_q;

	logic [7:0]         rom_idx;
	logic [14:0]        mag;
	logic               negate;
	logic signed [15:0] sample_d;

	assign s1_ready = !valid_q || out_ready;

	// Quadrant folding onto the quarter-wave table, then chip sign
	always_comb begin
		rom_idx  = s1_data.quad[0] ? ~s1_data.idx : s1_data.idx;
		mag      = COS_ROM[rom_idx];
		negate   = (s1_data.quad[0] ^ s1_data.quad[1]) ^ ~s1_data.chip_sign;
		sample_d = negate ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (s1_ready)
			valid_q <= s1_valid;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (s1_ready && s1_valid) begin
			sample_q <= sample_d;
			taken_q  <= s1_data.bit_taken;
			sign_q   <= s1_data.chip_sign;
		end
	end

	assign out_valid = valid_q;
	assign sample    = sample_q;
	assign bit_taken = taken_q;
	assign chip_sign = sign_q;

	`DSSSB_ASSERT_NOW(a_no_min, valid_q, sample_q != 16'sh8000, "sample out of range")
	`DSSSB_ASSERT_NEXT(a_load, s1_valid && s1_ready, valid_q, "stage 1 transaction dropped")
	`DSSSB_ASSERT_NOW(a_rise_src, $rose(valid_q), $past(s1_valid),
		"output valid without a stage 1 item")

endmodule
`default_nettype wire
